// File: hdl/wps_pkg.sv
// ---------------------------------------------------------------------------
// Waypoint path simplifier package
// Shared constants and the cell kind type for the path simplifier chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wps_pkg;

  // Default coordinate width of a path point.
  localparam int COORD_WIDTH_DEF = 12;

  // Number of cells in the chain.
  localparam int NUM_CELLS = 3;

  // Test applied by a cell to its pending point.
  typedef enum logic {
    KIND_COLLINEAR,
    KIND_NEIGHBOUR
  } cell_kind_t;

endpackage

// File: hdl/wps_cell.sv
// ---------------------------------------------------------------------------
// Path simplifier cell
// Holds an anchor and a pending point, decides whether the pending point is
// kept, and queues kept points in a three-entry output queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wps_cell #(
  parameter int                  COORD_WIDTH = wps_pkg::COORD_WIDTH_DEF,
  parameter wps_pkg::cell_kind_t KIND        = wps_pkg::KIND_COLLINEAR
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_x,
  input  logic [COORD_WIDTH-1:0] in_y,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_x,
  output logic [COORD_WIDTH-1:0] out_y,
  output logic                   out_last
);
  import wps_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int EW    = 2 * W + 1;
  localparam int DEPTH = 3;

  localparam logic [1:0] HELD_NONE   = 2'd0;
  localparam logic [1:0] HELD_ANCHOR = 2'd1;
  localparam logic [1:0] HELD_BOTH   = 2'd2;

  logic [W-1:0]  anchor_x, anchor_y, pend_x, pend_y;
  logic [1:0]    held;
  logic [EW-1:0] queue [DEPTH];
  logic [EW-1:0] queue_next [DEPTH];
  logic [1:0]    count, count_next;

  logic               accept, pop, drop, keep_pend;
  logic               push0, push1;
  logic [EW-1:0]      e0, e1, q_ent;
  logic [1:0]         base;
  logic signed [W:0]  dx1, dx2, dy1, dy2;
  logic signed [2*W+1:0] prod_a, prod_b;
  logic               on_line, neighbour;

  assign in_ready  = (count <= 2'd1);
  assign accept    = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign {out_last, out_y, out_x} = queue[0];

  assign q_ent = {in_last, in_y, in_x};

  // Steps from anchor to pending and from pending to the new point.
  assign dx1 = $signed({1'b0, pend_x}) - $signed({1'b0, anchor_x});
  assign dy1 = $signed({1'b0, pend_y}) - $signed({1'b0, anchor_y});
  assign dx2 = $signed({1'b0, in_x}) - $signed({1'b0, pend_x});
  assign dy2 = $signed({1'b0, in_y}) - $signed({1'b0, pend_y});

  // Equal slopes checked by cross-multiplication, so no division is needed.
  assign prod_a = dy1 * dx2;
  assign prod_b = dy2 * dx1;

  assign on_line = ((dx1 == '0) && (dx2 == '0)) ||
                   ((dy1 == '0) && (dy2 == '0)) ||
                   ((dx1 != '0) && (dx2 != '0) && (prod_a == prod_b));

  assign neighbour = (dx1 >= -(W+1)'(1)) && (dx1 <= (W+1)'(1)) &&
                     (dy1 >= -(W+1)'(1)) && (dy1 <= (W+1)'(1)) &&
                     ((dx1 != '0) || (dy1 != '0));

  assign drop      = (KIND == KIND_NEIGHBOUR) ? neighbour : on_line;
  assign keep_pend = held[1] && !drop;

  always_comb begin
    push0 = 1'b0;
    push1 = 1'b0;
    e0    = q_ent;
    e1    = q_ent;
    if (accept) begin
      if (held == HELD_NONE) begin
        push0 = 1'b1;
      end else if (keep_pend) begin
        push0 = 1'b1;
        e0    = {1'b0, pend_y, pend_x};
        push1 = in_last;
      end else begin
        push0 = in_last;
      end
    end
  end

  // Shift queue: the head is always entry zero.
  always_comb begin
    base = count - {1'b0, pop};
    for (int i = 0; i < DEPTH; i++) begin
      if (pop && (i < DEPTH - 1)) begin
        queue_next[i] = queue[i+1];
      end else begin
        queue_next[i] = queue[i];
      end
      if (push0 && (2'(i) == base)) begin
        queue_next[i] = e0;
      end
      if (push1 && (2'(i) == base + 2'd1)) begin
        queue_next[i] = e1;
      end
    end
    count_next = base + {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      queue[i] <= queue_next[i];
    end
    if (rst) begin
      count <= 2'd0;
      held  <= HELD_NONE;
    end else begin
      count <= count_next;
      if (accept) begin
        if (held == HELD_NONE) begin
          if (!in_last) begin
            anchor_x <= in_x;
            anchor_y <= in_y;
            held     <= HELD_ANCHOR;
          end
        end else begin
          if (keep_pend) begin
            anchor_x <= pend_x;
            anchor_y <= pend_y;
          end
          pend_x <= in_x;
          pend_y <= in_y;
          held   <= in_last ? HELD_NONE : HELD_BOTH;
        end
      end
    end
  end

endmodule

// File: hdl/waypoint_path_simplifier_core.sv
// ---------------------------------------------------------------------------
// Waypoint path simplifier core
// Removes redundant points from a grid path streamed one point at a time.
// ---------------------------------------------------------------------------
// The input channel takes one path point per transfer (in_x, in_y, in_last),
// with in_last set on the final point of a path. The output channel gives the
// kept points in order, out_last marking the final kept point.
// Three cells form a chain: the first and third drop points that lie on a
// straight line between their neighbours, the second drops a point that is
// an 8-neighbour of the previous kept point. The first and last points of a
// path are always kept, and each cell starts a fresh path after a last point.
// A kept point passes through the three registered cell queues in turn.
// One point is taken every cycle while the first queue has room; a last
// point makes a cell emit two points, which can hold in_ready low in each
// cell the burst passes through. Each cell owns a three-entry output queue,
// so a stall at the output backs up through the queues and then holds
// in_ready low without losing points. Reset empties every cell and queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module waypoint_path_simplifier_core #(
  parameter int COORD_WIDTH = wps_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_x,
  input  logic [COORD_WIDTH-1:0] in_y,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_x,
  output logic [COORD_WIDTH-1:0] out_y,
  output logic                   out_last
);
  import wps_pkg::*;

  logic                   lnk_valid [NUM_CELLS+1];
  logic                   lnk_ready [NUM_CELLS+1];
  logic [COORD_WIDTH-1:0] lnk_x     [NUM_CELLS+1];
  logic [COORD_WIDTH-1:0] lnk_y     [NUM_CELLS+1];
  logic                   lnk_last  [NUM_CELLS+1];

  assign lnk_valid[0] = in_valid;
  assign in_ready     = lnk_ready[0];
  assign lnk_x[0]     = in_x;
  assign lnk_y[0]     = in_y;
  assign lnk_last[0]  = in_last;

  assign out_valid            = lnk_valid[NUM_CELLS];
  assign lnk_ready[NUM_CELLS] = out_ready;
  assign out_x                = lnk_x[NUM_CELLS];
  assign out_y                = lnk_y[NUM_CELLS];
  assign out_last             = lnk_last[NUM_CELLS];

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    // The middle cell prunes neighbours, the outer cells prune straight runs.
    localparam cell_kind_t KIND_G = (g == 1) ? KIND_NEIGHBOUR : KIND_COLLINEAR;

    wps_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .KIND        (KIND_G)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lnk_valid[g]),
      .in_ready  (lnk_ready[g]),
      .in_x      (lnk_x[g]),
      .in_y      (lnk_y[g]),
      .in_last   (lnk_last[g]),
      .out_valid (lnk_valid[g+1]),
      .out_ready (lnk_ready[g+1]),
      .out_x     (lnk_x[g+1]),
      .out_y     (lnk_y[g+1]),
      .out_last  (lnk_last[g+1])
    );
  end

endmodule
